// ===== src/tefr_pkg.sv =====
// Shared constants, codes and helpers for the trace event record filter.
// Used by every module under src; depends on nothing else.
`default_nettype none

package tefr_pkg;

    // List storage
    localparam int LIST_DEPTH = 16;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

    // Field widths fixed by the item format
    localparam int OP_W        = 2;
    localparam int TYPE_W      = 32;
    localparam int VALUE_W     = 64;
    localparam int ENTRY_IDX_W = 4;
    localparam int FN_W        = 3;
    localparam int CNT_W       = 5;

    localparam int IN_FIELDS_W = TYPE_W + VALUE_W + ENTRY_IDX_W + VALUE_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_TYPE_FUNCTION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_FUNCTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_OP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_DEFAULT   = 3'd5;

    // Item operations
    localparam logic [OP_W-1:0] OP_FILTER      = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_TYPE  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE_VALUE = 2'd2;

    // Match functions
    localparam logic [FN_W-1:0] FN_ALL       = 3'd0;
    localparam logic [FN_W-1:0] FN_NONE      = 3'd1;
    localparam logic [FN_W-1:0] FN_EQUAL     = 3'd2;
    localparam logic [FN_W-1:0] FN_NOT_EQUAL = 3'd3;
    localparam logic [FN_W-1:0] FN_GREATER   = 3'd4;
    localparam logic [FN_W-1:0] FN_LESS      = 3'd5;
    localparam logic [FN_W-1:0] FN_RANGE     = 3'd6;

    // Combine operations
    localparam logic COMBINE_AND = 1'b0;
    localparam logic COMBINE_OR  = 1'b1;

    // Flip the sign bit so signed values order as unsigned ones
    localparam logic [VALUE_W-1:0] SIGN_BIAS = {1'b1, {(VALUE_W-1){1'b0}}};

    // Outcome of one compare step
    typedef struct packed {
        logic hit;
        logic stop;
    } match_res_t;

    // Limit a configured count to the list depth
    function automatic logic [LEN_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [LEN_W-1:0] r;
        if (32'(c) > LIST_DEPTH)
            r = LEN_W'(LIST_DEPTH);
        else
            r = LEN_W'(c);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/tefr_match.sv =====
// Shared compare unit: one list entry against the record field per cycle.
// Depends on tefr_pkg for function codes and the result struct.
`default_nettype none

module tefr_match (
    input  wire logic [tefr_pkg::FN_W-1:0]    fn,
    input  wire logic                         first,
    input  wire logic [tefr_pkg::VALUE_W-1:0] d,
    input  wire logic [tefr_pkg::VALUE_W-1:0] p,
    output tefr_pkg::match_res_t              res
);

    logic eq;
    logic gt;
    logic lt;

    // One wide unsigned compare serves every function
    assign eq = (d == p);
    assign gt = (d > p);
    assign lt = !eq && !gt;

    // Decide hit and early stop for this entry
    always_comb
    begin
        res.hit  = 1'b1;
        res.stop = 1'b1;
        unique case (fn)
            tefr_pkg::FN_NONE:
            begin
                res.hit  = 1'b0;
                res.stop = 1'b1;
            end
            tefr_pkg::FN_EQUAL:
            begin
                res.hit  = eq;
                res.stop = eq;
            end
            tefr_pkg::FN_NOT_EQUAL:
            begin
                res.hit  = !eq;
                res.stop = eq;
            end
            tefr_pkg::FN_GREATER:
            begin
                res.hit  = gt;
                res.stop = !gt;
            end
            tefr_pkg::FN_LESS:
            begin
                res.hit  = lt;
                res.stop = !lt;
            end
            tefr_pkg::FN_RANGE:
            begin
                // low bound on the first entry, high bound on the second
                if (first)
                begin
                    res.hit  = !lt;
                    res.stop = lt;
                end
                else
                begin
                    res.hit  = !gt;
                    res.stop = 1'b1;
                end
            end
            default:
            begin
                res.hit  = 1'b1;
                res.stop = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/trace_event_record_filter_core.sv =====
// A filter item steps from accept through S_TYPE_SCAN (skipped for an empty type list),
// S_DECIDE, S_VALUE_SCAN when needed and S_RESULT; writes and unused ops go to S_RESULT.
// Throughput: one item at a time; the shared compare unit looks at one list entry per
// cycle, and s_tready stays low until the result is handed to the output register, so the
// next item is taken in the cycle after that.
// Reset (rst_n, asynchronous, active low) clears control and configuration; the lists
// keep whatever they held and are undefined until written.
// Top level of the filter; depends on tefr_pkg and tefr_match.
`default_nettype none

module trace_event_record_filter_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tefr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tefr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // event_type, event_value, entry_index, entry_value, zero pad
    input  wire logic [tefr_pkg::IN_DATA_W-1:0]     s_tdata,
    // op
    input  wire logic [tefr_pkg::OP_W-1:0]          s_tuser,
    // result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // pass, zero pad
    output logic [tefr_pkg::OUT_DATA_W-1:0]         m_tdata,
    // was_filter
    output logic [0:0]                              m_tuser
);

    localparam int ETYPE_LSB  = 0;
    localparam int EVALUE_LSB = ETYPE_LSB + tefr_pkg::TYPE_W;
    localparam int EIDX_LSB   = EVALUE_LSB + tefr_pkg::VALUE_W;
    localparam int EVAL_LSB   = EIDX_LSB + tefr_pkg::ENTRY_IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TYPE_SCAN,
        S_DECIDE,
        S_VALUE_SCAN,
        S_RESULT
    } state_t;

    // Input field unpacking
    logic [tefr_pkg::OP_W-1:0]        in_op;
    logic [tefr_pkg::TYPE_W-1:0]      in_event_type;
    logic [tefr_pkg::VALUE_W-1:0]     in_event_value;
    logic [tefr_pkg::ENTRY_IDX_W-1:0] in_entry_index;
    logic [tefr_pkg::VALUE_W-1:0]     in_entry_value;
    logic                             in_acc;

    assign in_op          = s_tuser;
    assign in_event_type  = s_tdata[ETYPE_LSB +: tefr_pkg::TYPE_W];
    assign in_event_value = s_tdata[EVALUE_LSB +: tefr_pkg::VALUE_W];
    assign in_entry_index = s_tdata[EIDX_LSB +: tefr_pkg::ENTRY_IDX_W];
    assign in_entry_value = s_tdata[EVAL_LSB +: tefr_pkg::VALUE_W];

    // Configuration registers
    logic [tefr_pkg::FN_W-1:0]  type_fn_reg;
    logic [tefr_pkg::FN_W-1:0]  value_fn_reg;
    logic                       combine_reg;
    logic [tefr_pkg::CNT_W-1:0] type_cnt_reg;
    logic [tefr_pkg::CNT_W-1:0] value_cnt_reg;
    logic                       type_default_reg;

    // Sequencer state
    state_t                       state_reg;
    state_t                       state_next;
    logic [tefr_pkg::ADDR_W-1:0]  idx_reg;
    logic [tefr_pkg::ADDR_W-1:0]  idx_next;
    logic                         hit_reg;
    logic                         hit_next;
    logic                         res_pass_reg;
    logic                         res_pass_next;
    logic                         res_filter_reg;
    logic                         res_filter_next;
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic                         m_pass_reg;
    logic                         m_pass_next;
    logic                         m_filter_reg;
    logic                         m_filter_next;

    // Record held during the scan
    logic [tefr_pkg::TYPE_W-1:0]  etype_reg;
    logic [tefr_pkg::VALUE_W-1:0] evalue_reg;

    // List memories and their registered read data
    logic [tefr_pkg::TYPE_W-1:0]  type_mem [tefr_pkg::LIST_DEPTH];
    logic [tefr_pkg::VALUE_W-1:0] value_mem [tefr_pkg::LIST_DEPTH];
    logic [tefr_pkg::TYPE_W-1:0]  type_rd_reg;
    logic [tefr_pkg::VALUE_W-1:0] value_rd_reg;
    logic [tefr_pkg::ADDR_W-1:0]  rd_addr;
    logic [tefr_pkg::ADDR_W-1:0]  wr_addr;
    logic                         wr_in_range;

    // Compare unit operands
    logic                         scan_values;
    logic [tefr_pkg::FN_W-1:0]    cmp_fn;
    logic [tefr_pkg::VALUE_W-1:0] cmp_d;
    logic [tefr_pkg::VALUE_W-1:0] cmp_p;
    tefr_pkg::match_res_t         mres;
    logic [tefr_pkg::LEN_W-1:0]   type_len;
    logic [tefr_pkg::LEN_W-1:0]   value_len;
    logic [tefr_pkg::LEN_W-1:0]   scan_len;
    logic                         scan_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tefr_pkg::OUT_DATA_W-1){1'b0}}, m_pass_reg};
    assign m_tuser  = m_filter_reg;

    // Take configuration writes; unknown indexes change nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_fn_reg      <= tefr_pkg::FN_ALL;
            value_fn_reg     <= tefr_pkg::FN_ALL;
            combine_reg      <= tefr_pkg::COMBINE_AND;
            type_cnt_reg     <= '0;
            value_cnt_reg    <= '0;
            type_default_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tefr_pkg::REG_TYPE_FUNCTION:  type_fn_reg      <= cfg_data[tefr_pkg::FN_W-1:0];
                tefr_pkg::REG_VALUE_FUNCTION: value_fn_reg     <= cfg_data[tefr_pkg::FN_W-1:0];
                tefr_pkg::REG_COMBINE_OP:     combine_reg      <= cfg_data[0];
                tefr_pkg::REG_TYPE_COUNT:     type_cnt_reg     <= cfg_data[tefr_pkg::CNT_W-1:0];
                tefr_pkg::REG_VALUE_COUNT:    value_cnt_reg    <= cfg_data[tefr_pkg::CNT_W-1:0];
                tefr_pkg::REG_TYPE_DEFAULT:   type_default_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign type_len  = tefr_pkg::clamp_count(type_cnt_reg);
    assign value_len = tefr_pkg::clamp_count(value_cnt_reg);

    // Read address: entry 0 while waiting, the next entry while scanning
    always_comb
    begin
        unique case (state_reg)
            S_TYPE_SCAN,
            S_VALUE_SCAN: rd_addr = idx_reg + tefr_pkg::ADDR_W'(1);
            default:      rd_addr = '0;
        endcase
    end

    assign wr_addr     = tefr_pkg::ADDR_W'(in_entry_index);
    assign wr_in_range = (32'(in_entry_index) < tefr_pkg::LIST_DEPTH);

    // List memories: write on accept of a write item, read every cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && in_op == tefr_pkg::OP_WRITE_TYPE && wr_in_range)
            type_mem[wr_addr] <= in_entry_value[tefr_pkg::TYPE_W-1:0];
        type_rd_reg <= type_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_op == tefr_pkg::OP_WRITE_VALUE && wr_in_range)
            value_mem[wr_addr] <= in_entry_value;
        value_rd_reg <= value_mem[rd_addr];
    end

    // Hold the record for the scan
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            etype_reg  <= in_event_type;
            evalue_reg <= in_event_value;
        end
    end

    // Steer the shared compare unit at the list being scanned
    assign scan_values = (state_reg == S_VALUE_SCAN);
    assign cmp_fn      = scan_values ? value_fn_reg : type_fn_reg;
    assign cmp_d       = scan_values ? (evalue_reg ^ tefr_pkg::SIGN_BIAS)
                                     : {{(tefr_pkg::VALUE_W-tefr_pkg::TYPE_W){1'b0}}, etype_reg};
    assign cmp_p       = scan_values ? (value_rd_reg ^ tefr_pkg::SIGN_BIAS)
                                     : {{(tefr_pkg::VALUE_W-tefr_pkg::TYPE_W){1'b0}}, type_rd_reg};
    assign scan_len    = scan_values ? value_len : type_len;
    assign scan_last   = ((tefr_pkg::LEN_W'(idx_reg) + tefr_pkg::LEN_W'(1)) == scan_len);

    tefr_match u_match (
        .fn    (cmp_fn),
        .first (idx_reg == '0),
        .d     (cmp_d),
        .p     (cmp_p),
        .res   (mres)
    );

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        res_pass_next   = res_pass_reg;
        res_filter_next = res_filter_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_pass_next     = m_pass_reg;
        m_filter_next   = m_filter_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next = '0;
                    if (in_op == tefr_pkg::OP_FILTER)
                    begin
                        res_filter_next = 1'b1;
                        if (type_len == '0)
                        begin
                            hit_next   = type_default_reg;
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            state_next = S_TYPE_SCAN;
                        end
                    end
                    else
                    begin
                        res_filter_next = 1'b0;
                        res_pass_next   = 1'b0;
                        state_next      = S_RESULT;
                    end
                end
            end
            S_TYPE_SCAN:
            begin
                if (mres.stop || scan_last)
                begin
                    hit_next   = mres.hit;
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + tefr_pkg::ADDR_W'(1);
                end
            end
            S_DECIDE:
            begin
                // short-circuit on the type result, else scan values, or take the type result when no values
                idx_next = '0;
                priority if (combine_reg == tefr_pkg::COMBINE_AND && !hit_reg)
                begin
                    res_pass_next = 1'b0;
                    state_next    = S_RESULT;
                end
                else if (combine_reg == tefr_pkg::COMBINE_OR && hit_reg)
                begin
                    res_pass_next = 1'b1;
                    state_next    = S_RESULT;
                end
                else if (value_len == '0)
                begin
                    res_pass_next = hit_reg;
                    state_next    = S_RESULT;
                end
                else
                begin
                    state_next = S_VALUE_SCAN;
                end
            end
            S_VALUE_SCAN:
            begin
                if (mres.stop || scan_last)
                begin
                    res_pass_next = mres.hit;
                    state_next    = S_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + tefr_pkg::ADDR_W'(1);
                end
            end
            S_RESULT:
            begin
                // hand over once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_pass_next   = res_pass_reg;
                    m_filter_next = res_filter_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            res_pass_reg   <= 1'b0;
            res_filter_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_pass_reg     <= 1'b0;
            m_filter_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hit_reg        <= hit_next;
            res_pass_reg   <= res_pass_next;
            res_filter_reg <= res_filter_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_pass_reg     <= m_pass_next;
            m_filter_reg   <= m_filter_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tefr_checker.sv =====
// Port-level checks for the trace event record filter, bound to the top level.
// Depends on tefr_pkg and trace_event_record_filter_core.
`default_nettype none

module tefr_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [tefr_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire logic [0:0]                         m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Drop ready after taking an item: one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an item was accepted");

    // Write and unused items never pass
    a_write_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tdata[0])
        else $error("non-filter result shows pass");

    // Keep the pad bits clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[tefr_pkg::OUT_DATA_W-1:1] == '0)
        else $error("result pad bits set");

endmodule

bind trace_event_record_filter_core tefr_checker u_tefr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for trace_event_record_filter_core: directed and random items,
// with a class that predicts each filter verdict and checks it. Depends on tefr_pkg.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_ITEMS = 100;

    // Codes the package leaves unnamed
    localparam logic [tefr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [tefr_pkg::FN_W-1:0] FN_SPARE  = 3'd7;

    localparam logic [tefr_pkg::VALUE_W-1:0] VALUE_MIN = {1'b1, {(tefr_pkg::VALUE_W-1){1'b0}}};
    localparam logic [tefr_pkg::VALUE_W-1:0] VALUE_MAX = {1'b0, {(tefr_pkg::VALUE_W-1){1'b1}}};
    localparam logic [tefr_pkg::TYPE_W-1:0]  TYPE_MAX  = {tefr_pkg::TYPE_W{1'b1}};

    typedef struct {
        logic pass_bit;
        logic was_filter;
    } verdict_t;

    // Predicts the verdict of every accepted item and checks results in order
    class filter_verdict_board;
        logic [tefr_pkg::TYPE_W-1:0]  type_list [tefr_pkg::LIST_DEPTH];
        logic [tefr_pkg::VALUE_W-1:0] value_list [tefr_pkg::LIST_DEPTH];
        logic [tefr_pkg::FN_W-1:0]    type_fn;
        logic [tefr_pkg::FN_W-1:0]    value_fn;
        logic                         combine;
        logic [tefr_pkg::CNT_W-1:0]   type_count;
        logic [tefr_pkg::CNT_W-1:0]   value_count;
        logic                         type_default;
        verdict_t                     pending_verdicts [$];
        int                           errors;
        int                           results_seen;

        function new();
            type_fn      = tefr_pkg::FN_ALL;
            value_fn     = tefr_pkg::FN_ALL;
            combine      = tefr_pkg::COMBINE_AND;
            type_count   = '0;
            value_count  = '0;
            type_default = 1'b1;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report(string what);
            $display("MISMATCH at result %0d: %s", results_seen, what);
            errors++;
        endtask

        function void write_reg(logic [tefr_pkg::CFG_IDX_W-1:0] idx,
                                logic [tefr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tefr_pkg::REG_TYPE_FUNCTION:  type_fn      = data[tefr_pkg::FN_W-1:0];
                tefr_pkg::REG_VALUE_FUNCTION: value_fn     = data[tefr_pkg::FN_W-1:0];
                tefr_pkg::REG_COMBINE_OP:     combine      = data[0];
                tefr_pkg::REG_TYPE_COUNT:     type_count   = data[tefr_pkg::CNT_W-1:0];
                tefr_pkg::REG_VALUE_COUNT:    value_count  = data[tefr_pkg::CNT_W-1:0];
                tefr_pkg::REG_TYPE_DEFAULT:   type_default = data[0];
                default: ;
            endcase
        endfunction

        // Walk the first n entries of one list; values are compared with the sign bit flipped
        function logic scan_entries(logic [tefr_pkg::FN_W-1:0] fn, bit use_values, int n,
                                    logic [tefr_pkg::VALUE_W-1:0] d);
            logic                         r;
            logic                         stop;
            logic [tefr_pkg::VALUE_W-1:0] p;
            r = 1'b0;
            stop = 1'b0;
            for (int i = 0; i < n && !stop; i++) begin
                p = use_values ? (value_list[i] ^ tefr_pkg::SIGN_BIAS) : {32'b0, type_list[i]};
                case (fn)
                    tefr_pkg::FN_NONE:      begin r = 1'b0; stop = 1'b1; end
                    tefr_pkg::FN_EQUAL:     begin r = (d == p); stop = r; end
                    tefr_pkg::FN_NOT_EQUAL: begin r = (d != p); stop = !r; end
                    tefr_pkg::FN_GREATER:   begin r = (d > p);  stop = !r; end
                    tefr_pkg::FN_LESS:      begin r = (d < p);  stop = !r; end
                    tefr_pkg::FN_RANGE:
                    begin
                        if (i == 0) begin
                            r = (d >= p);
                            stop = !r;
                        end else if (i == 1) begin
                            r = (d <= p);
                            stop = 1'b1;
                        end else begin
                            stop = 1'b1;
                        end
                    end
                    default:      begin r = 1'b1; stop = 1'b1; end
                endcase
            end
            return r;
        endfunction

        function logic decide_pass(logic [tefr_pkg::TYPE_W-1:0] etype,
                                   logic [tefr_pkg::VALUE_W-1:0] evalue);
            logic r;
            int   n;
            r = type_default;
            n = (type_count > tefr_pkg::LIST_DEPTH) ? tefr_pkg::LIST_DEPTH : int'(type_count);
            if (n > 0)
                r = scan_entries(type_fn, 1'b0, n, {32'b0, etype});
            // Short-circuit on the type verdict
            if (combine == tefr_pkg::COMBINE_AND && !r)
                return 1'b0;
            if (combine == tefr_pkg::COMBINE_OR && r)
                return 1'b1;
            n = (value_count > tefr_pkg::LIST_DEPTH) ? tefr_pkg::LIST_DEPTH : int'(value_count);
            if (n > 0)
                r = scan_entries(value_fn, 1'b1, n, evalue ^ tefr_pkg::SIGN_BIAS);
            return r;
        endfunction

        function void note_item(logic [tefr_pkg::OP_W-1:0] op,
                                logic [tefr_pkg::TYPE_W-1:0] etype,
                                logic [tefr_pkg::VALUE_W-1:0] evalue,
                                logic [tefr_pkg::ENTRY_IDX_W-1:0] idx,
                                logic [tefr_pkg::VALUE_W-1:0] evv);
            verdict_t v;
            v.pass_bit   = 1'b0;
            v.was_filter = 1'b0;
            case (op)
                tefr_pkg::OP_FILTER:
                begin
                    v.pass_bit   = decide_pass(etype, evalue);
                    v.was_filter = 1'b1;
                end
                tefr_pkg::OP_WRITE_TYPE:  type_list[idx]  = evv[tefr_pkg::TYPE_W-1:0];
                tefr_pkg::OP_WRITE_VALUE: value_list[idx] = evv;
                default: ;
            endcase
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        task check_result(logic pass_bit, logic was_filter);
            verdict_t v;
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("unexpected result pass=%0b was_filter=%0b",
                                 pass_bit, was_filter));
            end else begin
                v = pending_verdicts.pop_front();
                if (pass_bit !== v.pass_bit)
                    report($sformatf("pass got %0b want %0b", pass_bit, v.pass_bit));
                if (was_filter !== v.was_filter)
                    report($sformatf("was_filter got %0b want %0b", was_filter, v.was_filter));
            end
        endtask

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tefr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tefr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tefr_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [tefr_pkg::OP_W-1:0]       s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic [tefr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;

    filter_verdict_board sb = new();
    bit quiet = 1'b0;
    int cycle_count = 0;

    trace_event_record_filter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    // Take results and stall the output at random
    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata[0], m_tuser[0]);
            m_tready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    // Offer one item, idling first at random; tvalid stays high on return
    task send_item(logic [tefr_pkg::OP_W-1:0] op, logic [tefr_pkg::TYPE_W-1:0] etype,
                   logic [tefr_pkg::VALUE_W-1:0] evalue,
                   logic [tefr_pkg::ENTRY_IDX_W-1:0] idx,
                   logic [tefr_pkg::VALUE_W-1:0] evv);
        if (!quiet && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(tefr_pkg::IN_DATA_W-tefr_pkg::IN_FIELDS_W){1'b0}},
                     evv, idx, evalue, etype};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(op, etype, evalue, idx, evv);
    endtask

    task filter_item(logic [tefr_pkg::TYPE_W-1:0] etype, logic [tefr_pkg::VALUE_W-1:0] evalue);
        send_item(tefr_pkg::OP_FILTER, etype, evalue, 4'($urandom), {$urandom, $urandom});
    endtask

    // Hold the sender until every outstanding result is back
    task drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task write_reg(logic [tefr_pkg::CFG_IDX_W-1:0] idx, logic [tefr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Drain, then write every register
    task set_config(logic [tefr_pkg::FN_W-1:0] tfn, logic [tefr_pkg::FN_W-1:0] vfn,
                    logic comb, logic [tefr_pkg::CNT_W-1:0] tcnt,
                    logic [tefr_pkg::CNT_W-1:0] vcnt, logic tdef);
        drain_results();
        write_reg(tefr_pkg::REG_TYPE_FUNCTION, tefr_pkg::CFG_DATA_W'(tfn));
        write_reg(tefr_pkg::REG_VALUE_FUNCTION, tefr_pkg::CFG_DATA_W'(vfn));
        write_reg(tefr_pkg::REG_COMBINE_OP, tefr_pkg::CFG_DATA_W'(comb));
        write_reg(tefr_pkg::REG_TYPE_COUNT, tcnt);
        write_reg(tefr_pkg::REG_VALUE_COUNT, vcnt);
        write_reg(tefr_pkg::REG_TYPE_DEFAULT, tefr_pkg::CFG_DATA_W'(tdef));
        cfg_valid <= 1'b0;
    endtask

    // Types near list entries, extremes or anything
    function automatic logic [tefr_pkg::TYPE_W-1:0] pick_type();
        logic [tefr_pkg::TYPE_W-1:0] base;
        base = sb.type_list[$urandom_range(0, 3)];
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return base;
            2: return base + 1;
            3: return base - 1;
            4: return $urandom_range(0, 1) ? TYPE_MAX : '0;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [tefr_pkg::VALUE_W-1:0] pick_value();
        logic [tefr_pkg::VALUE_W-1:0] base;
        logic [31:0]                  near_zero;
        base = sb.value_list[$urandom_range(0, 3)];
        near_zero = 32'($urandom_range(0, 200)) - 32'd100;
        case ($urandom_range(0, 6))
            0: return {$urandom, $urandom};
            1: return base;
            2: return base + 1;
            3: return base - 1;
            4: return VALUE_MIN;
            5: return VALUE_MAX;
            default: return {{32{near_zero[31]}}, near_zero};
        endcase
    endfunction

    task random_phase(int ph);
        logic [tefr_pkg::CNT_W-1:0] cnt [2];
        int                         pick;
        for (int k = 0; k < 2; k++) begin
            case ($urandom_range(0, 9))
                0:       cnt[k] = '0;
                7:       cnt[k] = 5'd16;
                8:       cnt[k] = 5'($urandom_range(17, 31));
                9:       cnt[k] = 5'($urandom_range(5, 15));
                default: cnt[k] = 5'($urandom_range(1, 4));
            endcase
        end
        if (ph == 0)
            set_config(tefr_pkg::FN_ALL, tefr_pkg::FN_ALL, tefr_pkg::COMBINE_AND,
                       5'd0, 5'd0, 1'b0);
        else if (ph == 1)
            set_config(FN_SPARE, FN_SPARE, tefr_pkg::COMBINE_OR, 5'd31, 5'd31, 1'b1);
        else
            set_config(3'($urandom), 3'($urandom), 1'($urandom), cnt[0], cnt[1],
                       1'($urandom));
        quiet = (ph == 4);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_item(tefr_pkg::OP_WRITE_TYPE, $urandom, {$urandom, $urandom},
                          4'($urandom), {$urandom, pick_type()});
            else if (pick < 24)
                send_item(tefr_pkg::OP_WRITE_VALUE, $urandom, {$urandom, $urandom},
                          4'($urandom), pick_value());
            else if (pick < 28)
                send_item(OP_UNUSED, $urandom, {$urandom, $urandom}, 4'($urandom),
                          {$urandom, $urandom});
            else
                filter_item(pick_type(), pick_value());
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty lists: the type default decides, then the value list is absent
        filter_item('0, VALUE_MIN);
        filter_item(TYPE_MAX, VALUE_MAX);
        send_item(OP_UNUSED, TYPE_MAX, VALUE_MAX, 4'hf, {tefr_pkg::VALUE_W{1'b1}});
        set_config(tefr_pkg::FN_ALL, tefr_pkg::FN_ALL, tefr_pkg::COMBINE_OR, 5'd0, 5'd0, 1'b0);
        filter_item(32'd100, '0);

        // Load every entry before any list is read
        for (int i = 0; i < tefr_pkg::LIST_DEPTH; i++) begin
            case (i)
                0:       send_item(tefr_pkg::OP_WRITE_TYPE, '0, '0, 4'(i), 64'd100);
                1:       send_item(tefr_pkg::OP_WRITE_TYPE, '0, '0, 4'(i), 64'd200);
                2:       send_item(tefr_pkg::OP_WRITE_TYPE, '0, '0, 4'(i), '0);
                3:       send_item(tefr_pkg::OP_WRITE_TYPE, '0, '0, 4'(i),
                                   {tefr_pkg::VALUE_W{1'b1}});
                default: send_item(tefr_pkg::OP_WRITE_TYPE, '0, '0, 4'(i),
                                   {$urandom, $urandom});
            endcase
            case (i)
                0:       send_item(tefr_pkg::OP_WRITE_VALUE, '0, '0, 4'(i), -64'sd50);
                1:       send_item(tefr_pkg::OP_WRITE_VALUE, '0, '0, 4'(i), 64'sd50);
                2:       send_item(tefr_pkg::OP_WRITE_VALUE, '0, '0, 4'(i), VALUE_MIN);
                3:       send_item(tefr_pkg::OP_WRITE_VALUE, '0, '0, 4'(i), VALUE_MAX);
                default: send_item(tefr_pkg::OP_WRITE_VALUE, '0, '0, 4'(i),
                                   {$urandom, $urandom});
            endcase
        end

        // Range bounds on both lists, edges inside and out
        set_config(tefr_pkg::FN_RANGE, tefr_pkg::FN_RANGE, tefr_pkg::COMBINE_AND,
                   5'd2, 5'd2, 1'b1);
        filter_item(32'd99, '0);
        filter_item(32'd100, -64'sd50);
        filter_item(32'd200, 64'sd50);
        filter_item(32'd201, '0);
        filter_item(32'd150, -64'sd51);
        filter_item(32'd150, 64'sd51);
        filter_item(32'd150, VALUE_MIN);
        filter_item(32'd150, VALUE_MAX);

        // Count above depth, equal and not equal under OR
        set_config(tefr_pkg::FN_EQUAL, tefr_pkg::FN_NOT_EQUAL, tefr_pkg::COMBINE_OR,
                   5'd31, 5'd16, 1'b0);
        filter_item(32'd200, '0);
        filter_item(32'd5, -64'sd50);
        filter_item(32'd5, 64'sd12345);
        filter_item(TYPE_MAX, VALUE_MAX);

        // Greater and less than both scanned entries
        set_config(tefr_pkg::FN_GREATER, tefr_pkg::FN_LESS, tefr_pkg::COMBINE_AND,
                   5'd2, 5'd2, 1'b1);
        filter_item(32'd201, -64'sd51);
        filter_item(32'd150, -64'sd51);
        filter_item(32'd201, 64'sd50);

        // Unused function code and none
        set_config(FN_SPARE, tefr_pkg::FN_NONE, tefr_pkg::COMBINE_AND, 5'd16, 5'd1, 1'b1);
        filter_item(32'd7, '0);
        set_config(tefr_pkg::FN_LESS, tefr_pkg::FN_GREATER, tefr_pkg::COMBINE_OR,
                   5'd1, 5'd3, 1'b0);
        filter_item(32'd99, '0);
        filter_item(32'd100, VALUE_MAX);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            random_phase(ph);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
